/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition this cycle implies consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/btm_pkg.sv */
// Shared constants, codes and types of the barycentric texture mapper.
// No dependencies; used by the interfaces, the core and the checker.
package btm_pkg;

  localparam int TEX_WIDTH  = 512;
  localparam int TEX_HEIGHT = 512;
  localparam int FRAC_BITS  = 12;

  localparam int DST_W     = 10;
  localparam int TEX_W     = 9;
  localparam int COLOR_W   = 24;
  localparam int CFG_W     = 2 * DST_W;
  localparam int CFG_IDX_W = 3;

  localparam int DIFF_W  = DST_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DET_W   = PROD_W + 2;
  localparam int WGT_W   = 2 * DST_W + 1;
  localparam int NUM_W   = WGT_W + TEX_W;
  localparam int QUO_W   = TEX_W + FRAC_BITS;
  localparam int LERP_W  = FRAC_BITS + 9;
  localparam int BLEND_W = 2 * FRAC_BITS + 10;

  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = 2 * (TEX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam int FIFO_DEPTH = 64;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_SHADE = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DST0,
    CFG_DST1,
    CFG_DST2,
    CFG_SRC0,
    CFG_SRC1,
    CFG_SRC2,
    CFG_BILINEAR
  } cfg_reg_e;

  typedef struct packed {
    logic               kind;
    logic [DST_W-1:0]   px;
    logic [DST_W-1:0]   py;
    logic [TEX_W-1:0]   wx;
    logic [TEX_W-1:0]   wy;
    logic [COLOR_W-1:0] wc;
    logic               in_tri;
  } meta_t;

  typedef struct packed {
    logic               inside_res;
    logic [COLOR_W-1:0] color;
    logic [DST_W-1:0]   out_x;
    logic [DST_W-1:0]   out_y;
  } res_t;

endpackage

/* rtl/btm_if.sv */
// Valid/ready channel interfaces of the texture mapper: pixel input, result output.
// Depends on btm_pkg for field widths.
interface btm_pix_if import btm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [DST_W-1:0]   pixel_x;
  logic [DST_W-1:0]   pixel_y;
  logic [TEX_W-1:0]   texel_x;
  logic [TEX_W-1:0]   texel_y;
  logic [COLOR_W-1:0] texel_color;

  modport source (output valid, kind, pixel_x, pixel_y, texel_x, texel_y, texel_color,
                  input ready);
  modport sink   (input valid, kind, pixel_x, pixel_y, texel_x, texel_y, texel_color,
                  output ready);
endinterface

interface btm_res_if import btm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [COLOR_W-1:0] color;
  logic [DST_W-1:0]   out_x;
  logic [DST_W-1:0]   out_y;

  modport source (output valid, inside_res, color, out_x, out_y, input ready);
  modport sink   (input valid, inside_res, color, out_x, out_y, output ready);
endinterface

/* rtl/barycentric_texture_mapper_core.sv */
// Barycentric texture mapper: triangle test, texture-space mapping and texel fetch.
// Depends on btm_pkg and on the channel interfaces in btm_if.sv.
//
// Usage:
//  in_i carries write beats (kind 0: texel_x/texel_y/texel_color go to the texture
//  store) and shade beats (kind 1: pixel_x/pixel_y). Each shade beat gives exactly
//  one beat on out_o; write beats give none. Results leave in order.
//  The configuration port writes the triangle vertices and the filter mode; write
//  it only while no beat is in flight.
//  Throughput: one beat per cycle on in_i while in_i.ready is high. The pipeline
//  never stalls; the texture store is four banks split by texel x/y parity, so
//  all four bilinear neighbors are read in the same cycle, one read port per bank.
//  A shade beat passes the input register, the determinant and weighting stages,
//  the divider (one quotient bit per stage), texel fetch, the blends and the FIFO.
//  A result FIFO of FIFO_DEPTH entries sits behind the pipeline; in_i.ready drops
//  only when FIFO_DEPTH shade beats are accepted but not yet delivered, so a
//  stalled receiver blocks input only once that many results are outstanding.
//  Reset clears the configuration, the credit counter, the valid line and the FIFO
//  pointers; the texture store holds no defined content until written.
module barycentric_texture_mapper_core import btm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  btm_pix_if.sink              in_i,
  btm_res_if.source            out_o
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [TEX_W+1:0] TEX_WIDTH_V  = (TEX_W+2)'(TEX_WIDTH);
  localparam logic [TEX_W+1:0] TEX_HEIGHT_V = (TEX_W+2)'(TEX_HEIGHT);

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [DST_W-1:0] a,
                                                     input logic [DST_W-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic wok(input logic signed [DET_W-1:0] n,
                               input logic signed [DET_W-1:0] det);
    if (det > 0) return (n >= 0) && (n < det);
    return (n <= 0) && (n > det);
  endfunction

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0]   dst_q [3];
  logic [2*TEX_W-1:0] src_q [3];
  logic               bil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        dst_q[i] <= '0;
        src_q[i] <= '0;
      end
      bil_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DST0:     dst_q[0] <= cfg_data_i;
        CFG_DST1:     dst_q[1] <= cfg_data_i;
        CFG_DST2:     dst_q[2] <= cfg_data_i;
        CFG_SRC0:     src_q[0] <= cfg_data_i[2*TEX_W-1:0];
        CFG_SRC1:     src_q[1] <= cfg_data_i[2*TEX_W-1:0];
        CFG_SRC2:     src_q[2] <= cfg_data_i[2*TEX_W-1:0];
        CFG_BILINEAR: bil_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [DST_W-1:0] dx [3];
  logic [DST_W-1:0] dy [3];
  logic [TEX_W-1:0] sx [3];
  logic [TEX_W-1:0] sy [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[i] = dst_q[i][CFG_W-1:DST_W];
      dy[i] = dst_q[i][DST_W-1:0];
      sx[i] = src_q[i][2*TEX_W-1:TEX_W];
      sy[i] = src_q[i][TEX_W-1:0];
    end
  end

  // ---------------- credit counter ----------------
  logic [CNT_W-1:0] in_flight_q;
  logic in_acc, shade_acc, out_acc;

  assign in_i.ready = (in_flight_q != CNT_W'(FIFO_DEPTH));
  assign in_acc     = in_i.valid && in_i.ready;
  assign shade_acc  = in_acc && (in_i.kind == KIND_SHADE);
  assign out_acc    = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= '0;
    end else if (shade_acc && !out_acc) begin
      in_flight_q <= in_flight_q + CNT_W'(1);
    end else if (!shade_acc && out_acc) begin
      in_flight_q <= in_flight_q - CNT_W'(1);
    end
  end

  // ---------------- pipeline valid line ----------------
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, b_v_q, c_v_q;
  logic dv_v_q [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) dv_v_q[k] <= 1'b0;
    end else begin
      s0_v_q    <= in_acc;
      s1_v_q    <= s0_v_q;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      dv_v_q[0] <= s4_v_q;
      for (int k = 0; k < QUO_W; k++) dv_v_q[k+1] <= dv_v_q[k];
      b_v_q     <= dv_v_q[QUO_W];
      c_v_q     <= b_v_q;
    end
  end

  // ---------------- stage 0: input register ----------------
  meta_t s0_meta_q, s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_meta_q.kind   <= in_i.kind;
      s0_meta_q.px     <= in_i.pixel_x;
      s0_meta_q.py     <= in_i.pixel_y;
      s0_meta_q.wx     <= in_i.texel_x;
      s0_meta_q.wy     <= in_i.texel_y;
      s0_meta_q.wc     <= in_i.texel_color;
      s0_meta_q.in_tri <= 1'b0;
    end
  end

  // ---------------- stage 1: determinant products ----------------
  logic signed [PROD_W-1:0] s1_nu0_q, s1_nu1_q, s1_nv0_q, s1_nv1_q, s1_w0_q, s1_w1_q;
  logic signed [DIFF_W-1:0] qx, qy;

  assign qx = sdiff(s0_meta_q.px, dx[2]);
  assign qy = sdiff(s0_meta_q.py, dy[2]);

  always_ff @(posedge clk_i) begin
    s1_meta_q <= s0_meta_q;
    s1_nu0_q  <= sdiff(dy[1], dy[2]) * qx;
    s1_nu1_q  <= sdiff(dx[2], dx[1]) * qy;
    s1_nv0_q  <= sdiff(dy[2], dy[0]) * qx;
    s1_nv1_q  <= sdiff(dx[0], dx[2]) * qy;
    s1_w0_q   <= sdiff(dx[1], dx[0]) * sdiff(dy[2], dy[0]);
    s1_w1_q   <= sdiff(dy[1], dy[0]) * sdiff(dx[2], dx[0]);
  end

  // ---------------- stage 2: determinants ----------------
  logic signed [DET_W-1:0] s2_nu_q, s2_nv_q, s2_wz_q;

  always_ff @(posedge clk_i) begin
    s2_meta_q <= s1_meta_q;
    s2_nu_q   <= DET_W'(s1_nu0_q) + DET_W'(s1_nu1_q);
    s2_nv_q   <= DET_W'(s1_nv0_q) + DET_W'(s1_nv1_q);
    s2_wz_q   <= DET_W'(s1_w0_q) - DET_W'(s1_w1_q);
  end

  // ---------------- stage 3: inside test, sign fold ----------------
  logic signed [DET_W-1:0] nw, nu_a, nv_a, nw_a, wz_a;
  logic                    s3_in;
  meta_t                   s3_meta_d;
  logic [WGT_W-1:0]        s3_w_q [3];
  logic [WGT_W-1:0]        s3_den_q;

  always_comb begin
    nw    = s2_wz_q - s2_nu_q - s2_nv_q;
    s3_in = (s2_wz_q != 0) && wok(s2_nu_q, s2_wz_q) && wok(s2_nv_q, s2_wz_q)
            && wok(nw, s2_wz_q);
    s3_meta_d        = s2_meta_q;
    s3_meta_d.in_tri = s3_in;
    if (s2_wz_q < 0) begin
      nu_a = -s2_nu_q;
      nv_a = -s2_nv_q;
      nw_a = -nw;
      wz_a = -s2_wz_q;
    end else begin
      nu_a = s2_nu_q;
      nv_a = s2_nv_q;
      nw_a = nw;
      wz_a = s2_wz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_meta_q <= s3_meta_d;
    s3_w_q[0] <= nu_a[WGT_W-1:0];
    s3_w_q[1] <= nv_a[WGT_W-1:0];
    s3_w_q[2] <= nw_a[WGT_W-1:0];
    s3_den_q  <= wz_a[WGT_W-1:0];
  end

  // ---------------- stage 4: weighted texture coordinates ----------------
  logic [NUM_W-1:0] s4_px_q [3];
  logic [NUM_W-1:0] s4_py_q [3];
  logic [WGT_W-1:0] s4_den_q;

  always_ff @(posedge clk_i) begin
    s4_meta_q <= s3_meta_q;
    s4_den_q  <= s3_den_q;
    for (int i = 0; i < 3; i++) begin
      s4_px_q[i] <= NUM_W'(s3_w_q[i]) * NUM_W'(sx[i]);
      s4_py_q[i] <= NUM_W'(s3_w_q[i]) * NUM_W'(sy[i]);
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [NUM_W-1:0] numx, numy;
  logic [WGT_W-1:0] dv_rx_q [QUO_W+1];
  logic [WGT_W-1:0] dv_ry_q [QUO_W+1];
  logic [QUO_W-1:0] dv_lx_q [QUO_W+1];
  logic [QUO_W-1:0] dv_ly_q [QUO_W+1];
  logic [QUO_W-1:0] dv_qx_q [QUO_W+1];
  logic [QUO_W-1:0] dv_qy_q [QUO_W+1];
  logic [WGT_W-1:0] dv_den_q [QUO_W+1];
  meta_t            dv_meta_q [QUO_W+1];
  logic [WGT_W:0]   tx_try [QUO_W];
  logic [WGT_W:0]   ty_try [QUO_W];
  logic             gex [QUO_W];
  logic             gey [QUO_W];
  logic [WGT_W:0]   rx_nx [QUO_W];
  logic [WGT_W:0]   ry_nx [QUO_W];

  assign numx = s4_px_q[0] + s4_px_q[1] + s4_px_q[2];
  assign numy = s4_py_q[0] + s4_py_q[1] + s4_py_q[2];

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      tx_try[k] = {dv_rx_q[k], dv_lx_q[k][QUO_W-1]};
      ty_try[k] = {dv_ry_q[k], dv_ly_q[k][QUO_W-1]};
      gex[k]    = tx_try[k] >= {1'b0, dv_den_q[k]};
      gey[k]    = ty_try[k] >= {1'b0, dv_den_q[k]};
      rx_nx[k]  = gex[k] ? tx_try[k] - {1'b0, dv_den_q[k]} : tx_try[k];
      ry_nx[k]  = gey[k] ? ty_try[k] - {1'b0, dv_den_q[k]} : ty_try[k];
    end
  end

  always_ff @(posedge clk_i) begin
    // quotient fits QUO_W bits, so the high part of the dividend starts below den
    dv_rx_q[0]   <= numx[NUM_W-1:TEX_W];
    dv_ry_q[0]   <= numy[NUM_W-1:TEX_W];
    dv_lx_q[0]   <= {numx[TEX_W-1:0], {FRAC_BITS{1'b0}}};
    dv_ly_q[0]   <= {numy[TEX_W-1:0], {FRAC_BITS{1'b0}}};
    dv_qx_q[0]   <= '0;
    dv_qy_q[0]   <= '0;
    dv_den_q[0]  <= s4_den_q;
    dv_meta_q[0] <= s4_meta_q;
    for (int k = 0; k < QUO_W; k++) begin
      dv_rx_q[k+1]   <= rx_nx[k][WGT_W-1:0];
      dv_ry_q[k+1]   <= ry_nx[k][WGT_W-1:0];
      dv_lx_q[k+1]   <= dv_lx_q[k] << 1;
      dv_ly_q[k+1]   <= dv_ly_q[k] << 1;
      dv_qx_q[k+1]   <= {dv_qx_q[k][QUO_W-2:0], gex[k]};
      dv_qy_q[k+1]   <= {dv_qy_q[k][QUO_W-2:0], gey[k]};
      dv_den_q[k+1]  <= dv_den_q[k];
      dv_meta_q[k+1] <= dv_meta_q[k];
    end
  end

  // ---------------- stage A: texel addressing and store access ----------------
  meta_t                 a_meta;
  logic [FRAC_BITS-1:0]  a_ax, a_by;
  logic [TEX_W-1:0]      a_x0, a_y0, a_x0n, a_y0n, bx, by;
  logic [TEX_W:0]        a_x1, a_y1;
  logic                  a_oob;
  logic [BANK_AW-1:0]    tex_raddr [NUM_BANKS];
  logic [BANK_AW-1:0]    tex_waddr;
  logic [BANK_SEL_W-1:0] tex_wbank;
  logic                  tex_we;

  always_comb begin
    a_meta = dv_meta_q[QUO_W];
    a_ax   = bil_q ? dv_qx_q[QUO_W][FRAC_BITS-1:0] : '0;
    a_by   = bil_q ? dv_qy_q[QUO_W][FRAC_BITS-1:0] : '0;
    a_x0   = dv_qx_q[QUO_W][QUO_W-1:FRAC_BITS];
    a_y0   = dv_qy_q[QUO_W][QUO_W-1:FRAC_BITS];
    a_x0n  = a_x0 + TEX_W'(1);
    a_y0n  = a_y0 + TEX_W'(1);
    a_x1   = {1'b0, a_x0} + (TEX_W+1)'(a_ax != '0);
    a_y1   = {1'b0, a_y0} + (TEX_W+1)'(a_by != '0);
    a_oob  = ({1'b0, a_x1} >= TEX_WIDTH_V) || ({1'b0, a_y1} >= TEX_HEIGHT_V);
    // each bank holds one parity class, so it sees exactly one neighbor
    for (int b = 0; b < NUM_BANKS; b++) begin
      bx = (a_x0[0] == b[0]) ? a_x0 : a_x0n;
      by = (a_y0[0] == b[1]) ? a_y0 : a_y0n;
      tex_raddr[b] = {by[TEX_W-1:1], bx[TEX_W-1:1]};
    end
    tex_we    = dv_v_q[QUO_W] && (a_meta.kind == KIND_WRITE);
    tex_waddr = {a_meta.wy[TEX_W-1:1], a_meta.wx[TEX_W-1:1]};
    tex_wbank = {a_meta.wy[0], a_meta.wx[0]};
  end

  logic [COLOR_W-1:0] tex_mem  [NUM_BANKS][BANK_DEPTH];
  logic [COLOR_W-1:0] tex_rd_q [NUM_BANKS];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (tex_we && (tex_wbank == BANK_SEL_W'(b))) begin
        tex_mem[b][tex_waddr] <= a_meta.wc;
      end
      tex_rd_q[b] <= tex_mem[b][tex_raddr[b]];
    end
  end

  meta_t                b_meta_q;
  logic [FRAC_BITS-1:0] b_ax_q, b_by_q;
  logic                 b_oob_q, b_xp_q, b_yp_q;

  always_ff @(posedge clk_i) begin
    b_meta_q <= a_meta;
    b_ax_q   <= a_ax;
    b_by_q   <= a_by;
    b_oob_q  <= a_oob;
    b_xp_q   <= a_x0[0];
    b_yp_q   <= a_y0[0];
  end

  // ---------------- stage B: horizontal blend ----------------
  logic [COLOR_W-1:0]  t00, t01, t10, t11;
  logic [FRAC_BITS:0]  b_inv_a;
  logic [LERP_W-1:0]   top_d [3];
  logic [LERP_W-1:0]   bot_d [3];

  always_comb begin
    // drop neighbors with zero weight; their entries may never have been written
    t00     = tex_rd_q[{b_yp_q, b_xp_q}];
    t01     = (b_ax_q != '0) ? tex_rd_q[{b_yp_q, ~b_xp_q}] : '0;
    t10     = (b_by_q != '0) ? tex_rd_q[{~b_yp_q, b_xp_q}] : '0;
    t11     = ((b_ax_q != '0) && (b_by_q != '0)) ? tex_rd_q[{~b_yp_q, ~b_xp_q}] : '0;
    b_inv_a = ONE - {1'b0, b_ax_q};
    for (int c = 0; c < 3; c++) begin
      top_d[c] = LERP_W'(b_inv_a) * LERP_W'(t00[8*c +: 8])
               + LERP_W'(b_ax_q) * LERP_W'(t01[8*c +: 8]);
      bot_d[c] = LERP_W'(b_inv_a) * LERP_W'(t10[8*c +: 8])
               + LERP_W'(b_ax_q) * LERP_W'(t11[8*c +: 8]);
    end
  end

  meta_t                c_meta_q;
  logic [FRAC_BITS-1:0] c_by_q;
  logic                 c_oob_q;
  logic [LERP_W-1:0]    c_top_q [3];
  logic [LERP_W-1:0]    c_bot_q [3];

  always_ff @(posedge clk_i) begin
    c_meta_q <= b_meta_q;
    c_by_q   <= b_by_q;
    c_oob_q  <= b_oob_q;
    for (int c = 0; c < 3; c++) begin
      c_top_q[c] <= top_d[c];
      c_bot_q[c] <= bot_d[c];
    end
  end

  // ---------------- stage C: vertical blend, result push ----------------
  logic [FRAC_BITS:0]   c_inv_b;
  logic [BLEND_W-1:0]   blend [3];
  logic [BLEND_W-2*FRAC_BITS-1:0] chv [3];
  logic [COLOR_W-1:0]   c_color;
  res_t                 push_res;
  logic                 push;

  always_comb begin
    c_inv_b = ONE - {1'b0, c_by_q};
    for (int c = 0; c < 3; c++) begin
      blend[c] = BLEND_W'(c_inv_b) * BLEND_W'(c_top_q[c])
               + BLEND_W'(c_by_q) * BLEND_W'(c_bot_q[c]);
      chv[c]   = blend[c][BLEND_W-1:2*FRAC_BITS];
      c_color[8*c +: 8] = (chv[c] > 255) ? 8'hFF : chv[c][7:0];
    end
    push                = c_v_q && (c_meta_q.kind == KIND_SHADE);
    push_res.inside_res = c_meta_q.in_tri;
    push_res.color      = (c_meta_q.in_tri && !c_oob_q) ? c_color : '0;
    push_res.out_x      = c_meta_q.px;
    push_res.out_y      = c_meta_q.py;
  end

  // ---------------- result FIFO ----------------
  res_t               fifo_mem [FIFO_DEPTH];
  res_t               fifo_rd_q;
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   fifo_cnt_q;
  logic               out_v_q;
  logic               pop;

  // fetch into the output register when it is empty or drains this cycle
  assign pop = (fifo_cnt_q != '0) && (!out_v_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (push) fifo_mem[wr_ptr_q] <= push_res;
    if (pop)  fifo_rd_q <= fifo_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (push && !pop)      fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
      else if (!push && pop) fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
      if (pop)               out_v_q <= 1'b1;
      else if (out_o.ready)  out_v_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.inside_res = fifo_rd_q.inside_res;
  assign out_o.color      = fifo_rd_q.color;
  assign out_o.out_x      = fifo_rd_q.out_x;
  assign out_o.out_y      = fifo_rd_q.out_y;

endmodule

/* rtl/btm_checker.sv */
// Port-level checker for the texture mapper core, attached by bind.
// Depends on btm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module btm_checker import btm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_kind_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_inside_i,
  input logic [COLOR_W-1:0] out_color_i,
  input logic [DST_W-1:0]   out_x_i,
  input logic [DST_W-1:0]   out_y_i
);

  logic [CNT_W-1:0] pend_q;
  logic shade_beat, res_beat;

  assign shade_beat = in_valid_i && in_ready_i && (in_kind_i == KIND_SHADE);
  assign res_beat   = out_valid_i && out_ready_i;

  // track shade beats that still owe a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (shade_beat && !res_beat) begin
      pend_q <= pend_q + CNT_W'(1);
    end else if (!shade_beat && res_beat) begin
      pend_q <= pend_q - CNT_W'(1);
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_color_i) && $stable(out_inside_i) && $stable(out_x_i) && $stable(out_y_i),
    "stalled result beat changed")
  `ASSERT_PROP(a_no_extra_result, clk_i, rst_ni, out_valid_i |-> (pend_q != '0),
    "result beat without an outstanding shade beat")
  `ASSERT_PROP(a_credit_ready, clk_i, rst_ni, (pend_q < CNT_W'(FIFO_DEPTH)) |-> in_ready_i,
    "input stalled although result space is free")
  `ASSERT_PROP(a_outside_black, clk_i, rst_ni, (out_valid_i && !out_inside_i) |-> (out_color_i == '0),
    "outside pixel returned a nonzero color")

endmodule

bind barycentric_texture_mapper_core btm_checker u_btm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_kind_i    (in_i.kind),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_inside_i (out_o.inside_res),
  .out_color_i  (out_o.color),
  .out_x_i      (out_o.out_x),
  .out_y_i      (out_o.out_y)
);
